### rtl/psq_pkg.sv
// ----------------------------------------------------------------------------
// psq_pkg
// shared types for the positional sequence store: request and status codes,
// controller states and the per-cell control word
// ----------------------------------------------------------------------------
package psq_pkg;

  typedef enum logic [2:0] {
    REQ_INSERT_AT     = 3'd0,
    REQ_INSERT_SORTED = 3'd1,
    REQ_ERASE_AT      = 3'd2,
    REQ_REMOVE_ALL    = 3'd3,
    REQ_GET           = 3'd4,
    REQ_SET           = 3'd5,
    REQ_FIND          = 3'd6
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_EXEC   = 2'd1,
    S_REMOVE = 2'd2,
    S_DONE   = 2'd3
  } state_t;

  typedef struct packed {
    logic load;
    logic from_left;
    logic from_right;
  } cell_ctl_t;

endpackage

### rtl/psq_cell.sv
// ----------------------------------------------------------------------------
// psq_cell
// one storage cell of the sequence chain: holds one element, loads a new
// value or takes a neighbor's element, and flags a compare hit
// ----------------------------------------------------------------------------
module psq_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  psq_pkg::cell_ctl_t    ctl,
  input  logic                  active,
  input  logic                  mode_ge,
  input  logic [DATA_WIDTH-1:0] key,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] data,
  output logic                  flag
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data <= key;
    end else if (ctl.from_left) begin
      data <= left_data;
    end else if (ctl.from_right) begin
      data <= right_data;
    end
  end

  // hit: equal for find and remove, not-less for sorted insert
  assign flag = active && (mode_ge ? (key <= data) : (key == data));

endmodule

### rtl/positional_sequence_store_core.sv
// ----------------------------------------------------------------------------
// positional_sequence_store_core
// ordered sequence of up to CAPACITY elements kept in a chain of cells
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall) carries one request per transfer:
//   req_type, position and item_value. output channel (out_valid /
//   out_stall) returns exactly one result per request: status,
//   result_index, read_value, removed_count and element_count.
//   a transfer happens at a clock edge with valid high and stall low.
// timing
//   every request except remove_all passes from its input transfer through
//   the execute state, which registers its result, to the done state, which
//   loads that result into the output register; the next request is taken
//   only after the result is loaded. remove_all drops one matching element
//   per cycle in its remove state before it goes to the done state.
//   each request makes a single compare-and-shift pass over the cell chain;
//   remove_all repeats that pass per removed element and ends on one with no hit.
// reset
//   rst (synchronous, active high) empties the store and clears out_valid;
//   element storage itself is not cleared.
// backpressure
//   a finished result waits in the output register while out_stall is high;
//   the controller holds in its done state until the register frees up.
// ----------------------------------------------------------------------------
module positional_sequence_store_core #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [6:0]  position,
  input  logic [31:0] item_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [5:0]  result_index,
  output logic [31:0] read_value,
  output logic [6:0]  removed_count,
  output logic [6:0]  element_count
);

  // count width, compare width (at least the 7-bit position), value width
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > 7) ? CW : 7;
  localparam int VW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

  // controller state and the latched request
  psq_pkg::state_t state, state_next;
  logic [CW-1:0]   count, count_next;
  logic [CW-1:0]   removed, removed_next;
  psq_pkg::req_t   op_q;
  logic [XW-1:0]   pos_x;
  logic [DATA_WIDTH-1:0] key;
  logic [VW-1:0]   val_x;

  // result held between execute and output load
  psq_pkg::status_t res_status, res_status_next;
  logic [5:0]       res_index, res_index_next;
  logic [31:0]      res_read, res_read_next;

  // cell chain wiring
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]   flag;
  logic [CAPACITY:0]     hit_below;   // hit_below[i]: some hit in cells below i
  logic                  any_hit;
  logic [XW-1:0]         count_x;
  logic [XW-1:0]         first_idx;
  logic [XW-1:0]         ins_k;
  logic                  ins_go, set_go, erase_go, rm_go;
  logic                  mode_ge;
  logic                  full;
  logic [VW-1:0]         rd_x;
  logic                  in_xfer, out_load;

  assign in_stall = (state != psq_pkg::S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign val_x    = VW'(item_value);
  assign count_x  = XW'(count);
  assign full     = (count_x == XW'(CAPACITY));
  assign mode_ge  = (op_q == psq_pkg::REQ_INSERT_SORTED);
  assign any_hit  = hit_below[CAPACITY];
  assign hit_below[0] = 1'b0;

  // the row of cells; on insert the cells above the insert point take their left
  // neighbor, on erase or remove the cells from the removed one up take their right
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam logic [XW-1:0] IDX = XW'(g);
    logic [DATA_WIDTH-1:0] left_d, right_d;
    psq_pkg::cell_ctl_t    ctl;

    if (g == 0) begin : g_first
      assign left_d = key;
    end else begin : g_mid_l
      assign left_d = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_d = cell_data[g];
    end else begin : g_mid_r
      assign right_d = cell_data[g+1];
    end

    assign ctl.load       = (ins_go && (IDX == ins_k)) || (set_go && (IDX == pos_x));
    assign ctl.from_left  = ins_go && (IDX > ins_k);
    assign ctl.from_right = (erase_go && (IDX >= pos_x)) || (rm_go && hit_below[g+1]);

    // running "hit seen" chain toward the tail
    assign hit_below[g+1] = hit_below[g] | flag[g];

    psq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .active     (IDX < count_x),
      .mode_ge    (mode_ge),
      .key        (key),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[g]),
      .flag       (flag[g])
    );
  end

  // index of the first hit; only one cell can be first
  always_comb begin
    first_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (flag[i] && !hit_below[i]) begin
        first_idx = first_idx | XW'(i);
      end
    end
  end

  // element read for get
  always_comb begin
    rd_x = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (XW'(i) == pos_x) begin
        rd_x = rd_x | VW'(cell_data[i]);
      end
    end
  end

  // next state, chain controls and result
  always_comb begin
    state_next      = state;
    count_next      = count;
    removed_next    = removed;
    res_status_next = res_status;
    res_index_next  = res_index;
    res_read_next   = res_read;
    ins_go          = 1'b0;
    set_go          = 1'b0;
    erase_go        = 1'b0;
    rm_go           = 1'b0;
    ins_k           = pos_x;
    out_load        = 1'b0;

    unique case (state)
      psq_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (psq_pkg::req_t'(req_type) == psq_pkg::REQ_REMOVE_ALL) begin
            state_next = psq_pkg::S_REMOVE;
          end else begin
            state_next = psq_pkg::S_EXEC;
          end
        end
      end

      psq_pkg::S_EXEC: begin
        res_status_next = psq_pkg::ST_OK;
        res_index_next  = '0;
        res_read_next   = '0;
        unique case (op_q)
          psq_pkg::REQ_INSERT_AT: begin
            if (pos_x > count_x) begin
              res_status_next = psq_pkg::ST_RANGE;
            end else if (full) begin
              res_status_next = psq_pkg::ST_FULL;
            end else begin
              ins_go         = 1'b1;
              count_next     = CW'(count + 1'b1);
              res_index_next = pos_x[5:0];
            end
          end
          psq_pkg::REQ_INSERT_SORTED: begin
            ins_k = any_hit ? first_idx : count_x;
            if (full) begin
              res_status_next = psq_pkg::ST_FULL;
            end else begin
              ins_go         = 1'b1;
              count_next     = CW'(count + 1'b1);
              res_index_next = ins_k[5:0];
            end
          end
          psq_pkg::REQ_ERASE_AT: begin
            if (pos_x >= count_x) begin
              res_status_next = psq_pkg::ST_RANGE;
            end else begin
              erase_go   = 1'b1;
              count_next = CW'(count - 1'b1);
            end
          end
          psq_pkg::REQ_GET: begin
            if (pos_x >= count_x) begin
              res_status_next = psq_pkg::ST_RANGE;
            end else begin
              res_read_next = rd_x[31:0];
            end
          end
          psq_pkg::REQ_SET: begin
            if (pos_x >= count_x) begin
              res_status_next = psq_pkg::ST_RANGE;
            end else begin
              set_go = 1'b1;
            end
          end
          psq_pkg::REQ_FIND: begin
            if (any_hit) begin
              res_index_next = first_idx[5:0];
            end else begin
              res_status_next = psq_pkg::ST_MISSING;
            end
          end
          default: begin
            // unused code: no change, plain ok result
          end
        endcase
        state_next = psq_pkg::S_DONE;
      end

      psq_pkg::S_REMOVE: begin
        // drop the first match each cycle until none is left
        if (any_hit) begin
          rm_go        = 1'b1;
          count_next   = CW'(count - 1'b1);
          removed_next = CW'(removed + 1'b1);
        end else begin
          res_status_next = psq_pkg::ST_OK;
          res_index_next  = '0;
          res_read_next   = '0;
          state_next      = psq_pkg::S_DONE;
        end
      end

      psq_pkg::S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = psq_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = psq_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= psq_pkg::S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request latch, result and output registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_q    <= psq_pkg::req_t'(req_type);
      pos_x   <= XW'(position);
      key     <= val_x[DATA_WIDTH-1:0];
      removed <= '0;
    end else begin
      removed <= removed_next;
    end
    res_status <= res_status_next;
    res_index  <= res_index_next;
    res_read   <= res_read_next;
    if (out_load) begin
      status        <= res_status;
      result_index  <= res_index;
      read_value    <= res_read;
      removed_count <= 7'(XW'(removed));
      element_count <= count_x[6:0];
    end
  end

endmodule
